### hdl/spc_pkg.sv
package spc_pkg;

  // sizes
  localparam int RECORDS  = 64;
  localparam int RULES    = 17;
  localparam int REC_AW   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int IDX_W    = REC_AW + 1;
  localparam int RATE_DIV = 1000;
  localparam int QDEPTH   = 2;
  localparam int Q_AW     = $clog2(QDEPTH);

  // register indexes
  localparam logic [1:0] CFG_STUCK_REPEATS   = 2'd0;
  localparam logic [1:0] CFG_STUCK_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_USE_TIME_SCALE  = 2'd2;

  // input kinds
  localparam logic [1:0] KIND_CHECK     = 2'd0;
  localparam logic [1:0] KIND_CLEAR_ONE = 2'd1;
  localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;
  localparam logic [1:0] KIND_RESERVED  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_STUCK   = 3'd2,
    ST_INVALID = 3'd3,
    ST_RATE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_CHECK,
    OP_RANGE_FAIL,
    OP_INVALID,
    OP_CLEAR_ONE,
    OP_CLEAR_ALL,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_SCAN_RD,
    BS_SCAN_CMP,
    BS_EVAL1,
    BS_EVAL2,
    BS_EVAL3,
    BS_EVAL4,
    BS_RESULT
  } bstate_t;

  typedef struct packed {
    logic [7:0]         pid;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic [20:0]        rate;
    logic               do_range;
    logic               do_stuck;
    logic               do_rate;
  } rule_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         pid;
    logic signed [23:0] sample;
    logic [31:0]        now_ms;
    logic [20:0]        rate;
    logic               do_stuck;
    logic               do_rate;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         pid;
    logic signed [23:0] last;
    logic               has;
    logic [7:0]         run;
    logic [31:0]        last_ms;
  } record_t;

  typedef struct packed {
    logic [7:0] repeats;
    logic [7:0] tolerance;
    logic       use_ts;
  } cfg_t;

  localparam rule_t RULE_ROM [RULES] = '{
    '{8'h04, 24'sd0,      24'sd25600,   21'd51200,   1'b1, 1'b1, 1'b1},
    '{8'h05, -24'sd10240, 24'sd55040,   21'd5120,    1'b1, 1'b1, 1'b1},
    '{8'h06, -24'sd25600, 24'sd25395,   21'd20480,   1'b0, 1'b1, 1'b0},
    '{8'h07, -24'sd25600, 24'sd25395,   21'd10240,   1'b0, 1'b1, 1'b0},
    '{8'h0B, 24'sd0,      24'sd65280,   21'd51200,   1'b1, 1'b1, 1'b1},
    '{8'h0C, 24'sd0,      24'sd4194240, 21'd2048000, 1'b1, 1'b1, 1'b1},
    '{8'h0D, 24'sd0,      24'sd65280,   21'd25600,   1'b1, 1'b1, 1'b1},
    '{8'h0E, -24'sd16384, 24'sd16256,   21'd20480,   1'b0, 1'b1, 1'b1},
    '{8'h0F, -24'sd10240, 24'sd55040,   21'd2560,    1'b1, 1'b1, 1'b1},
    '{8'h10, 24'sd0,      24'sd167769,  21'd102400,  1'b1, 1'b1, 1'b1},
    '{8'h11, 24'sd0,      24'sd25600,   21'd51200,   1'b1, 1'b1, 1'b1},
    '{8'h2F, 24'sd0,      24'sd25600,   21'd2560,    1'b1, 1'b1, 1'b1},
    '{8'h33, 24'sd17920,  24'sd28160,   21'd1280,    1'b1, 1'b1, 1'b1},
    '{8'h42, 24'sd0,      24'sd16776,   21'd5120,    1'b1, 1'b1, 1'b1},
    '{8'h46, -24'sd10240, 24'sd55040,   21'd1280,    1'b1, 1'b1, 1'b1},
    '{8'h5C, -24'sd10240, 24'sd53760,   21'd2560,    1'b1, 1'b1, 1'b1},
    '{8'h5E, 24'sd0,      24'sd838848,  21'd51200,   1'b1, 1'b1, 1'b1}
  };

  // first matching rule; a pid without a rule gets all tests disabled
  function automatic rule_t rule_find(logic [7:0] pid);
    rule_t r;
    logic  hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < RULES; i++) begin
      if (!hit && RULE_ROM[i].pid == pid) begin
        r   = RULE_ROM[i];
        hit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### hdl/spc_if.sv
interface spc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         pid;
  logic signed [23:0] sample;
  logic               sample_valid;
  logic [31:0]        now_ms;

  modport source (output valid, kind, pid, sample, sample_valid, now_ms, input ready);
  modport sink (input valid, kind, pid, sample, sample_valid, now_ms, output ready);
endinterface

interface spc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] checks_done;
  logic [31:0] checks_failed;

  modport source (output valid, status, checks_done, checks_failed, input ready);
  modport sink (input valid, status, checks_done, checks_failed, output ready);
endinterface

### hdl/spc_front.sv
module spc_front (
  spc_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output spc_pkg::cmd_t   push_data
);
  import spc_pkg::*;

  rule_t rule;
  logic  range_bad;

  // rule lookup and range test
  assign rule      = rule_find(in_ch.pid);
  assign range_bad = rule.do_range && (in_ch.sample < rule.lo || in_ch.sample > rule.hi);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // classify the item into a back-end command
  always_comb begin
    push_data          = '0;
    push_data.pid      = in_ch.pid;
    push_data.sample   = in_ch.sample;
    push_data.now_ms   = in_ch.now_ms;
    push_data.rate     = rule.rate;
    push_data.do_stuck = rule.do_stuck;
    push_data.do_rate  = rule.do_rate;
    unique case (in_ch.kind)
      KIND_CHECK: begin
        if (!in_ch.sample_valid) push_data.op = OP_INVALID;
        else if (range_bad)      push_data.op = OP_RANGE_FAIL;
        else                     push_data.op = OP_CHECK;
      end
      KIND_CLEAR_ONE: push_data.op = OP_CLEAR_ONE;
      KIND_CLEAR_ALL: push_data.op = OP_CLEAR_ALL;
      default:        push_data.op = OP_NOP;
    endcase
  end

endmodule

### hdl/spc_queue.sv
module spc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  spc_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output spc_pkg::cmd_t pop_data
);
  import spc_pkg::*;

  cmd_t            slot_r [QDEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != (Q_AW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

endmodule

### hdl/spc_back.sv
module spc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  spc_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  spc_pkg::cmd_t pop_data,
  spc_out_if.source     out_ch
);
  import spc_pkg::*;

  bstate_t          state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, used_r, used_nxt;
  record_t          rec_r, rec_nxt, rd_q_r;
  status_t          st_r, st_nxt, out_status_r, out_status_nxt;
  logic [24:0]      absd_r, absd_nxt;
  logic [31:0]      d_r, d_nxt;
  logic             scaled_r, scaled_nxt;
  logic [36:0]      pp_lo_r, pp_lo_nxt, pp_hi_r, pp_hi_nxt;
  logic [34:0]      thr_r, thr_nxt;
  logic [31:0]      check_r, check_nxt, fail_r, fail_nxt;
  logic             out_valid_r, out_valid_nxt;

  record_t          mem [RECORDS];
  logic             mem_we;
  record_t          mem_wd;

  logic signed [24:0] diff;
  logic [24:0]        absd;
  logic [7:0]         run_inc;
  logic [31:0]        d_cur;
  logic [52:0]        prod;
  logic               rate_bad;
  logic               slot_free;

  // sample against stored record
  assign diff    = 25'(cmd_r.sample) - 25'(rec_r.last);
  assign absd    = diff[24] ? 25'(-diff) : 25'(diff);
  assign run_inc = (rec_r.run == 8'hFF) ? rec_r.run : rec_r.run + 8'd1;
  assign d_cur   = cmd_r.now_ms - rec_r.last_ms;

  // rate test: with time scaling, limit = max(1, floor(rate*d/1000)), done without division; else limit = rate
  assign prod = {pp_hi_r, 16'b0} + 53'(pp_lo_r);
  always_comb begin
    rate_bad = 1'b0;
    if (cmd_r.do_rate && rec_r.has) begin
      if (scaled_r) begin
        if (prod < 53'(RATE_DIV)) rate_bad = (absd_r > 25'd1);
        else                      rate_bad = (prod < 53'(thr_r));
      end else begin
        rate_bad = (absd_r > 25'(cmd_r.rate));
      end
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    rec_nxt        = rec_r;
    st_nxt         = st_r;
    absd_nxt       = absd_r;
    d_nxt          = d_r;
    scaled_nxt     = scaled_r;
    pp_lo_nxt      = pp_lo_r;
    pp_hi_nxt      = pp_hi_r;
    thr_nxt        = thr_r;
    check_nxt      = check_r;
    fail_nxt       = fail_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    pop_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_wd         = rec_r;
    unique case (state_r)
      BS_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          cmd_nxt   = pop_data;
          idx_nxt   = '0;
          unique case (pop_data.op)
            OP_INVALID: begin
              st_nxt    = ST_INVALID;
              state_nxt = BS_RESULT;
            end
            OP_RANGE_FAIL: begin
              st_nxt    = ST_RANGE;
              state_nxt = BS_RESULT;
            end
            OP_NOP: begin
              st_nxt    = ST_OK;
              state_nxt = BS_RESULT;
            end
            default: begin
              st_nxt    = ST_OK;
              state_nxt = BS_SCAN_RD;
            end
          endcase
        end
      end
      BS_SCAN_RD: begin
        if (idx_r == used_r) begin
          // end of allocated records
          if (cmd_r.op == OP_CHECK && used_r < IDX_W'(RECORDS)) begin
            rec_nxt     = '0;
            rec_nxt.pid = cmd_r.pid;
            used_nxt    = used_r + 1'b1;
            state_nxt   = BS_EVAL1;
          end else begin
            state_nxt = BS_RESULT;
          end
        end else begin
          state_nxt = BS_SCAN_CMP;
        end
      end
      BS_SCAN_CMP: begin
        rec_nxt = rd_q_r;
        if (cmd_r.op == OP_CLEAR_ALL) begin
          mem_we     = 1'b1;
          mem_wd     = rd_q_r;
          mem_wd.has = 1'b0;
          mem_wd.run = '0;
          idx_nxt    = idx_r + 1'b1;
          state_nxt  = BS_SCAN_RD;
        end else if (rd_q_r.pid == cmd_r.pid) begin
          if (cmd_r.op == OP_CLEAR_ONE) begin
            mem_we     = 1'b1;
            mem_wd     = rd_q_r;
            mem_wd.has = 1'b0;
            mem_wd.run = '0;
            state_nxt  = BS_RESULT;
          end else begin
            state_nxt = BS_EVAL1;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = BS_SCAN_RD;
        end
      end
      BS_EVAL1: begin
        absd_nxt   = absd;
        d_nxt      = d_cur;
        scaled_nxt = cfg.use_ts && cmd_r.now_ms != '0 && rec_r.last_ms != '0 && d_cur != '0;
        state_nxt  = BS_EVAL2;
        // stuck test
        if (cmd_r.do_stuck && rec_r.has) begin
          if (absd < 25'(cfg.tolerance)) begin
            rec_nxt.run = run_inc;
            if (run_inc >= cfg.repeats) begin
              mem_we     = 1'b1;
              mem_wd     = rec_r;
              mem_wd.run = run_inc;
              st_nxt     = ST_STUCK;
              state_nxt  = BS_RESULT;
            end
          end else begin
            rec_nxt.run = '0;
          end
        end
      end
      BS_EVAL2: begin
        pp_lo_nxt = 37'(cmd_r.rate) * 37'(d_r[15:0]);
        thr_nxt   = 35'(absd_r) * 35'(RATE_DIV);
        state_nxt = BS_EVAL3;
      end
      BS_EVAL3: begin
        pp_hi_nxt = 37'(cmd_r.rate) * 37'(d_r[31:16]);
        state_nxt = BS_EVAL4;
      end
      BS_EVAL4: begin
        mem_we = 1'b1;
        mem_wd = rec_r;
        if (rate_bad) begin
          st_nxt = ST_RATE;
        end else begin
          mem_wd.last = cmd_r.sample;
          mem_wd.has  = 1'b1;
          if (cmd_r.now_ms != '0) mem_wd.last_ms = cmd_r.now_ms;
        end
        state_nxt = BS_RESULT;
      end
      BS_RESULT: begin
        if (slot_free) begin
          if (cmd_r.op == OP_CHECK || cmd_r.op == OP_RANGE_FAIL) check_nxt = check_r + 32'd1;
          if (st_r == ST_RANGE || st_r == ST_STUCK || st_r == ST_RATE) fail_nxt = fail_r + 32'd1;
          out_status_nxt = st_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      used_r      <= '0;
      check_r     <= '0;
      fail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      check_r     <= check_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    rec_r        <= rec_nxt;
    st_r         <= st_nxt;
    absd_r       <= absd_nxt;
    d_r          <= d_nxt;
    scaled_r     <= scaled_nxt;
    pp_lo_r      <= pp_lo_nxt;
    pp_hi_r      <= pp_hi_nxt;
    thr_r        <= thr_nxt;
    out_status_r <= out_status_nxt;
  end

  // record memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r[REC_AW-1:0]] <= mem_wd;
    rd_q_r <= mem[idx_r[REC_AW-1:0]];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.checks_done   = check_r;
  assign out_ch.checks_failed = fail_r;

endmodule

### hdl/sensor_plausibility_checker.sv
// channel  | role   | handshake      | payload
// in_ch    | sink   | valid / ready  | kind, pid, sample, sample_valid, now_ms
// out_ch   | source | valid / ready  | status, checks_done, checks_failed
// cfg_*    | write  | cfg_we         | cfg_index, cfg_wdata
//
// the time from acceptance to result valid is set by the linear record search:
// a check reads records up to its match, then runs its stuck and rate tests; a new
// record is placed after a scan of every record in use; a full-table miss and clear-all
// scan every record in use; invalid, range-fail and unused-kind items skip the search
// synchronous active-low reset clears counters, records in use and the queue
// a two-entry queue and the output register let each side stall on its own
module sensor_plausibility_checker (
  input  logic       clk,
  input  logic       rst_n,
  spc_in_if.sink     in_ch,
  spc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import spc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  cmd_t q_push_data, q_pop_data;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STUCK_REPEATS:   cfg_nxt.repeats   = cfg_wdata;
        CFG_STUCK_TOLERANCE: cfg_nxt.tolerance = cfg_wdata;
        CFG_USE_TIME_SCALE:  cfg_nxt.use_ts    = cfg_wdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeats   <= 8'd10;
      cfg_r.tolerance <= 8'd1;
      cfg_r.use_ts    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spc_front u_front (
    .in_ch      (in_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  spc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  spc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_ch    (out_ch)
  );

  // counters step by at most one per cycle
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_ch.checks_done == $past(out_ch.checks_done) ||
                      out_ch.checks_done == $past(out_ch.checks_done) + 32'd1))
    else $error("checks_done jumped");

  a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_ch.checks_failed == $past(out_ch.checks_failed) ||
                      out_ch.checks_failed == $past(out_ch.checks_failed) + 32'd1))
    else $error("checks_failed jumped");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
